### design/jpm_pkg.sv
// Package for the joint path metric block: sizes, mode codes and the
// per-waypoint record passed from the sample front end to the total back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jpm_pkg;

	// Joint limit per waypoint; later joints of a waypoint are ignored
	localparam int MAX_JOINTS = 8;

	localparam int POS_W    = 16;
	localparam int CNT_W    = $clog2(MAX_JOINTS + 1);
	localparam int IDX_W    = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
	localparam int ABS_W    = 16;
	localparam int SQ_W     = 2 * ABS_W;
	localparam int SQSUM_W  = 38;
	localparam int LIN_W    = SQ_W + 1 + $clog2(MAX_JOINTS);
	localparam int ROOT_W   = SQSUM_W / 2;
	localparam int REM_W    = ROOT_W + 3;
	localparam int STEP_W   = $clog2(ROOT_W);
	localparam int VAL_W    = LIN_W + 1;
	localparam int TOTAL_W  = 48;

	localparam logic [SQSUM_W-1:0] SQSUM_MAX = {SQSUM_W{1'b1}};
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	// Waypoint queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// metric_mode codes
	localparam logic [1:0] MODE_ABS    = 2'd0;
	localparam logic [1:0] MODE_EUCLID = 2'd1;
	localparam logic [1:0] MODE_SQUARE = 2'd2;

	// One finished waypoint, as handed to the back end
	typedef struct packed {
		logic [SQSUM_W-1:0] sqsum;    // clamped sum of squared moves
		logic [LIN_W-1:0]   lin;      // per-sample adds of the absolute/squared modes
		logic               root_en;  // add the square root of sqsum
		logic               last_wp;  // trajectory ends with this waypoint
	} wp_rec_t;

endpackage

`default_nettype wire

### design/joint_path_metric_core.sv
// Joint-space path metric. Joint samples (signed Q3.12) are taken at one per
// cycle unless a finished waypoint finds the waypoint queue full; the front
// end keeps them in a pipeline and turns each waypoint into a record. The back
// end takes a waypoint through its sum and add states, with a root state first
// in the Euclidean mode (not for a trajectory's first waypoint), where a square
// root yields one bit a cycle. A 4-deep waypoint queue sits between the two, so
// the front end goes on taking samples while the back end works, until it fills.
// The result of a trajectory is held in an output register until taken. metric_mode
// is written through the configuration channel, which is always ready.
// Depends on jpm_pkg, jpm_front, jpm_queue, jpm_back.
`timescale 1ns / 1ps
`default_nettype none

module joint_path_metric_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [15:0]  joint_position,
	input  wire logic         last_joint,
	input  wire logic         last_waypoint,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   metric_mode,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [47:0]       path_total,
	output logic              total_saturated
);
	import jpm_pkg::*;

	wp_rec_t push_rec, pop_rec;
	logic    rec_push, rec_full, rec_pop, rec_nonempty;

	// Sample front end
	jpm_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.joint_position (joint_position),
		.last_joint     (last_joint),
		.last_waypoint  (last_waypoint),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_mode       (metric_mode),
		.rec_push       (rec_push),
		.rec_full       (rec_full),
		.rec            (push_rec)
	);

	// Waypoint queue
	jpm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rec_push),
		.push_data (push_rec),
		.full      (rec_full),
		.pop       (rec_pop),
		.pop_data  (pop_rec),
		.nonempty  (rec_nonempty)
	);

	// Root and total back end
	jpm_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.rec_valid       (rec_nonempty),
		.rec_pop         (rec_pop),
		.rec             (pop_rec),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.path_total      (path_total),
		.total_saturated (total_saturated)
	);

endmodule

`default_nettype wire

### design/jpm_front.sv
// Front end of the joint path metric: takes joint samples, keeps the previous
// waypoint, forms per-sample moves and squares, and emits one record per waypoint.
// Depends on jpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jpm_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [15:0]              joint_position,
	input  wire logic                     last_joint,
	input  wire logic                     last_waypoint,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [1:0]               cfg_mode,
	output logic                          rec_push,
	input  wire logic                     rec_full,
	output jpm_pkg::wp_rec_t              rec
);
	import jpm_pkg::*;

	logic [POS_W-1:0]   prev_q [MAX_JOINTS];
	logic [CNT_W-1:0]   cnt_q;
	logic               first_q;
	logic [1:0]         mode_q;

	logic               s1_valid_q, s1_use, s1_lj, s1_lw, s1_first;
	logic [ABS_W-1:0]   s1_abs;
	logic [1:0]         s1_mode;

	logic               s2_valid_q, s2_use, s2_lj, s2_lw, s2_first;
	logic [ABS_W-1:0]   s2_abs;
	logic [SQ_W-1:0]    s2_sq;
	logic [1:0]         s2_mode;

	logic [SQSUM_W-1:0] sqsum_q;
	logic [LIN_W-1:0]   lin_q;

	logic               adv, accept, active;
	logic [IDX_W-1:0]   idx;
	logic [POS_W:0]     diff;
	logic [POS_W:0]     neg_diff;
	logic [SQSUM_W:0]   sqsum_wide;
	logic [SQSUM_W-1:0] sqsum_nxt;
	logic [LIN_W-1:0]   lin_add;
	logic [LIN_W-1:0]   lin_nxt;

	// Whole pipeline stalls only when a waypoint record cannot be queued
	assign adv       = !(s2_valid_q && s2_lj && rec_full);
	assign in_ready  = adv;
	assign accept    = in_valid && adv;
	assign cfg_ready = 1'b1;

	// Sample classification and move against the stored previous waypoint
	assign active   = (cnt_q < CNT_W'(MAX_JOINTS));
	assign idx      = cnt_q[IDX_W-1:0];
	assign diff     = {joint_position[POS_W-1], joint_position}
	                - {prev_q[idx][POS_W-1], prev_q[idx]};
	assign neg_diff = -diff;

	always_ff @(posedge clk) begin
		if (accept && active) begin
			prev_q[idx] <= joint_position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			first_q <= 1'b1;
			mode_q  <= MODE_ABS;
		end else begin
			if (cfg_valid) begin
				mode_q <= cfg_mode;
			end
			if (accept) begin
				if (last_joint) begin
					cnt_q   <= '0;
					first_q <= last_waypoint;
				end else if (active) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	// Stage 1: absolute move
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s1_use   <= active && !first_q;
			s1_abs   <= diff[POS_W] ? neg_diff[ABS_W-1:0] : diff[ABS_W-1:0];
			s1_mode  <= mode_q;
			s1_lj    <= last_joint;
			s1_lw    <= last_waypoint;
			s1_first <= first_q;
		end
	end

	// Stage 2: square of the move
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (adv) begin
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s2_use   <= s1_use;
			s2_abs   <= s1_abs;
			s2_sq    <= s1_abs * s1_abs;
			s2_mode  <= s1_mode;
			s2_lj    <= s1_lj;
			s2_lw    <= s1_lw;
			s2_first <= s1_first;
		end
	end

	// Waypoint accumulation: clamped square sum and the per-sample total adds
	always_comb begin
		lin_add = '0;
		if (s2_use) begin
			case (s2_mode)
				MODE_ABS:    lin_add = LIN_W'(s2_abs);
				MODE_SQUARE: lin_add = LIN_W'(s2_sq);
				default:     lin_add = '0;
			endcase
		end
	end

	assign sqsum_wide = {1'b0, sqsum_q} + (s2_use ? (SQSUM_W+1)'(s2_sq) : '0);
	assign sqsum_nxt  = sqsum_wide[SQSUM_W] ? SQSUM_MAX : sqsum_wide[SQSUM_W-1:0];
	assign lin_nxt    = lin_q + lin_add;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqsum_q <= '0;
			lin_q   <= '0;
		end else if (s2_valid_q && adv) begin
			if (s2_lj) begin
				sqsum_q <= '0;
				lin_q   <= '0;
			end else begin
				sqsum_q <= sqsum_nxt;
				lin_q   <= lin_nxt;
			end
		end
	end

	// Record of a finished waypoint
	assign rec_push     = s2_valid_q && s2_lj && !rec_full;
	assign rec.sqsum    = sqsum_nxt;
	assign rec.lin      = lin_nxt;
	assign rec.root_en  = !s2_first && (s2_mode == MODE_EUCLID);
	assign rec.last_wp  = s2_lw;

endmodule

`default_nettype wire

### design/jpm_queue.sv
// Short queue of waypoint records between front and back end.
// Depends on jpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jpm_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  jpm_pkg::wp_rec_t      push_data,
	output logic                  full,
	input  wire logic             pop,
	output jpm_pkg::wp_rec_t      pop_data,
	output logic                  nonempty
);
	import jpm_pkg::*;

	wp_rec_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QPTR_W:0]     count_q;
	logic                do_pop;

	assign full     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign pop_data = mem_q[rd_q];
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Pointers wrap naturally at a power-of-two depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### design/jpm_back.sv
// Back end of the joint path metric: per waypoint, an iterative square root in
// the Euclidean mode (one root bit a cycle), then a saturating add into the trajectory total.
// Depends on jpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jpm_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                rec_valid,
	output logic                     rec_pop,
	input  jpm_pkg::wp_rec_t         rec,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [47:0]              path_total,
	output logic                     total_saturated
);
	import jpm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ROOT = 4'b0010,
		ST_SUM  = 4'b0100,
		ST_ADD  = 4'b1000
	} back_state_t;

	back_state_t         state_q;
	logic [SQSUM_W-1:0]  rad_q;
	logic [REM_W-1:0]    rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [STEP_W-1:0]   step_q;
	logic [LIN_W-1:0]    lin_q;
	logic                last_q;
	logic [VAL_W-1:0]    val_q;
	logic [TOTAL_W-1:0]  total_q;
	logic                sat_q;
	logic                out_valid_q;
	logic [TOTAL_W-1:0]  out_total_q;
	logic                out_sat_q;

	logic [REM_W-1:0]    rem_sh, trial;
	logic                take;
	logic [TOTAL_W:0]    total_wide;
	logic                over;
	logic [TOTAL_W-1:0]  total_nxt;
	logic                add_go;
	logic                out_load;

	assign rec_pop = (state_q == ST_IDLE) && rec_valid;

	// One root digit: bring down two radicand bits, try subtracting 4*root+1
	assign rem_sh = {rem_q[REM_W-3:0], rad_q[SQSUM_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign take   = (rem_sh >= trial);

	// Saturating total update; a total below the max plus any value fits one extra bit
	assign total_wide = {1'b0, total_q} + (TOTAL_W+1)'(val_q);
	assign over       = total_wide[TOTAL_W];
	assign total_nxt  = over ? TOTAL_MAX : total_wide[TOTAL_W-1:0];
	assign add_go     = !(last_q && out_valid_q && !out_ready);
	assign out_load   = (state_q == ST_ADD) && add_go && last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Result register: loaded at a trajectory end, cleared once transferred
			out_valid_q <= out_load || (out_valid_q && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (rec_valid) begin
						state_q <= rec.root_en ? ST_ROOT : ST_SUM;
					end
				end
				ST_ROOT: begin
					if (step_q == STEP_W'(ROOT_W - 1)) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (add_go) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							total_q     <= '0;
							sat_q       <= 1'b0;
						end else begin
							total_q <= total_nxt;
							sat_q   <= sat_q | over;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rad_q  <= rec.sqsum;
				lin_q  <= rec.lin;
				last_q <= rec.last_wp;
				rem_q  <= '0;
				root_q <= '0;
				step_q <= '0;
			end
			ST_ROOT: begin
				rad_q  <= {rad_q[SQSUM_W-3:0], 2'b00};
				rem_q  <= take ? (rem_sh - trial) : rem_sh;
				root_q <= {root_q[ROOT_W-2:0], take};
				step_q <= step_q + STEP_W'(1);
			end
			ST_SUM: begin
				val_q <= VAL_W'(lin_q) + VAL_W'(root_q);
			end
			ST_ADD: begin
				if (add_go && last_q) begin
					out_total_q <= total_nxt;
					out_sat_q   <= sat_q | over;
				end
			end
			default: begin
				step_q <= '0;
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign path_total      = out_total_q;
	assign total_saturated = out_sat_q;

endmodule

`default_nettype wire

### design/jpm_checker.sv
// Port-level checks for joint_path_metric_core, bound to the top level.
// Depends on joint_path_metric_core ports only.
`timescale 1ns / 1ps
`default_nettype none

module jpm_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         in_valid,
	input wire logic         in_ready,
	input wire logic         last_joint,
	input wire logic         last_waypoint,
	input wire logic         out_valid,
	input wire logic         out_ready,
	input wire logic [47:0]  path_total,
	input wire logic         total_saturated
);

	logic [4:0] pend_q;
	logic       end_xfer, out_xfer;

	assign end_xfer = in_valid && in_ready && last_joint && last_waypoint;
	assign out_xfer = out_valid && out_ready;

	// Trajectory ends transferred in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({end_xfer, out_xfer})
				2'b10:   pend_q <= pend_q + 5'd1;
				2'b01:   pend_q <= pend_q - 5'd1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(path_total)
		&& $stable(total_saturated))
		else $error("result changed while stalled");

	// A flagged total is clamped at its maximum
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && total_saturated |-> path_total == 48'hFFFF_FFFF_FFFF)
		else $error("saturated total not at maximum");

	// No result without a trajectory end transferred in
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 5'd0)
		else $error("result without trajectory end");

	// A result rises only while a trajectory end is already counted as pending
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pend_q) != 5'd0)
		else $error("result appeared too early");

endmodule

bind joint_path_metric_core jpm_checker u_jpm_checker (.*);

`default_nettype wire
